// File: sv/swsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsr_pkg
// Types, constants and helpers for the single-wire sensor frame receiver.
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int FrameBits = 40;
  localparam int CountW    = $clog2(FrameBits + 1);

  localparam logic [6:0] NomAck  = 7'd80;
  localparam logic [6:0] NomLow  = 7'd50;
  localparam logic [6:0] NomZero = 7'd27;
  localparam logic [6:0] NomOne  = 7'd70;

  localparam int TempW   = 17;
  localparam int OffsetW = 10;
  localparam int TolW    = 8;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_ELAPSED  = 2'd1,
    OP_EDGE     = 2'd2,
    OP_CONSUMED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE            = 3'd0,
    PH_START           = 3'd1,
    PH_WAIT_ACK        = 3'd2,
    PH_ACK             = 3'd3,
    PH_WAIT_DATA_START = 3'd4,
    PH_WAIT_DATA       = 3'd5,
    PH_DATA            = 3'd6,
    PH_READY           = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_READY = 2'd2
  } status_t;

  typedef enum logic {
    CFG_TOLERANCE   = 1'b0,
    CFG_TEMP_OFFSET = 1'b1
  } cfg_idx_t;

  // width in us against nominal +/- tolerance, low bound may go negative
  function automatic logic in_window(input logic [14:0] width,
                                     input logic [6:0]  nominal,
                                     input logic [TolW-1:0] tol);
    logic signed [16:0] w;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    begin
      w  = signed'({2'b00, width});
      lo = signed'({10'd0, nominal}) - signed'({9'd0, tol});
      hi = signed'({10'd0, nominal}) + signed'({9'd0, tol});
      in_window = (w >= lo) && (w <= hi);
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/single_wire_sensor_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_receiver
// Host-side event handler for a single-wire humidity/temperature sensor read:
// pulse-width checks, bit shifting, checksum and temperature conversion.
//
//   channel | direction | tuser       | tdata
//   in_     | slave     | opcode      | timestamp
//   out_    | master    | -           | status, drive_low, edge_rising,
//           |           |             | humidity, temperature, ok, error
//   cfg_    | write     | -           | tolerance_us, temp_offset_tenths
//
// one request per cycle unless a stalled result holds; each request yields one result
// each result is registered in the single output register after the event logic
// rst_n (synchronous) returns the phase to idle and clears stored values
// a stalled result holds while the next request is taken only as it leaves
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_receiver
  import swsr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [15:0]         in_tdata,   // timestamp
  input  wire logic [1:0]          in_tuser,   // opcode
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [39:0]              out_tdata,  // status[1:0], drive_low, edge_rising,
                                               // humidity[19:4], temperature[36:20],
                                               // frame_ok, frame_error, zero pad
  input  wire logic                cfg_we,
  input  wire logic                cfg_addr,
  input  wire logic [OffsetW-1:0]  cfg_wdata
);

  logic [TolW-1:0]          tol_r;
  logic signed [OffsetW-1:0] offset_r;

  phase_t                   phase_r, phase_nxt;
  logic [15:0]              last_r, last_nxt;
  logic [FrameBits-1:0]     frame_r, frame_nxt;
  logic [CountW-1:0]        count_r, count_nxt;
  logic [15:0]              hum_r, hum_nxt;
  logic [TempW-1:0]         temp_r, temp_nxt;
  logic                     ok_nxt, err_nxt;

  logic                     out_valid_r;
  logic [39:0]              out_data_r, out_data_nxt;

  logic                     in_acc;
  op_t                      op;
  logic [15:0]              diff;
  logic [14:0]              width;
  logic                     win_ack, win_low, win_zero, win_one;
  logic [FrameBits-1:0]     shifted;
  logic [CountW-1:0]        count_inc;
  logic [7:0]               crc;
  logic [15:0]              t_raw;
  logic [15:0]              h_raw;
  logic [9:0]               sum;
  logic signed [TempW-1:0]  mag;
  logic signed [TempW-1:0]  temp_calc;

  status_t                  status;
  logic                     drive_low;
  logic                     rising;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign op         = op_t'(in_tuser);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TolW'(10);
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TOLERANCE:   tol_r    <= cfg_wdata[TolW-1:0];
        CFG_TEMP_OFFSET: offset_r <= signed'(cfg_wdata);
        default:         ;
      endcase
    end
  end

  // width and frame datapath
  assign diff      = in_tdata - last_r;
  assign width     = diff[15:1];
  assign win_ack   = in_window(width, NomAck, tol_r);
  assign win_low   = in_window(width, NomLow, tol_r);
  assign win_zero  = in_window(width, NomZero, tol_r);
  assign win_one   = !win_zero && in_window(width, NomOne, tol_r);
  assign shifted   = {frame_r[FrameBits-2:0], win_one};
  assign count_inc = count_r + CountW'(1);
  assign crc       = shifted[7:0];
  assign t_raw     = shifted[23:8];
  assign h_raw     = shifted[39:24];
  assign sum       = {2'b00, h_raw[7:0]} + {2'b00, h_raw[15:8]}
                   + {2'b00, t_raw[7:0]} + {2'b00, t_raw[15:8]};
  assign mag       = signed'({2'b00, t_raw[14:0]});
  assign temp_calc = (t_raw[15] ? -mag : mag)
                   + TempW'(offset_r);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    frame_nxt = frame_r;
    count_nxt = count_r;
    hum_nxt   = hum_r;
    temp_nxt  = temp_r;
    ok_nxt    = 1'b0;
    err_nxt   = 1'b0;
    unique case (op)
      OP_START: begin
        if (phase_r == PH_IDLE || phase_r == PH_READY) phase_nxt = PH_START;
      end
      OP_ELAPSED: begin
        if (phase_r == PH_START) begin
          phase_nxt = PH_WAIT_ACK;
          last_nxt  = in_tdata;
        end
      end
      OP_CONSUMED: begin
        phase_nxt = PH_IDLE;
        frame_nxt = '0;
        count_nxt = '0;
      end
      OP_EDGE: begin
        unique case (phase_r)
          PH_WAIT_ACK: begin
            last_nxt  = in_tdata;
            phase_nxt = PH_ACK;
          end
          PH_ACK, PH_WAIT_DATA_START: begin
            last_nxt = in_tdata;
            if (win_ack) begin
              phase_nxt = (phase_r == PH_ACK) ? PH_WAIT_DATA_START : PH_WAIT_DATA;
            end else begin
              phase_nxt = PH_IDLE;
              frame_nxt = '0;
              count_nxt = '0;
              err_nxt   = 1'b1;
            end
          end
          PH_WAIT_DATA: begin
            last_nxt = in_tdata;
            if (win_low) begin
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_IDLE;
              frame_nxt = '0;
              count_nxt = '0;
              err_nxt   = 1'b1;
            end
          end
          PH_DATA: begin
            last_nxt = in_tdata;
            if (win_zero || win_one) begin
              frame_nxt = shifted;
              count_nxt = count_inc;
              phase_nxt = PH_WAIT_DATA;
              if (count_inc == CountW'(FrameBits)) begin
                frame_nxt = '0;
                count_nxt = '0;
                if (sum[7:0] != crc) begin
                  phase_nxt = PH_IDLE;
                  err_nxt   = 1'b1;
                end else begin
                  temp_nxt  = temp_calc;
                  hum_nxt   = h_raw;
                  phase_nxt = PH_READY;
                  ok_nxt    = 1'b1;
                end
              end
            end else begin
              phase_nxt = PH_IDLE;
              frame_nxt = '0;
              count_nxt = '0;
              err_nxt   = 1'b1;
            end
          end
          PH_IDLE, PH_START, PH_READY: ;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // outputs from the new phase
  always_comb begin
    unique case (phase_nxt)
      PH_IDLE:  status = ST_IDLE;
      PH_READY: status = ST_READY;
      default:  status = ST_BUSY;
    endcase
    drive_low = (phase_nxt == PH_START);
    rising    = (phase_nxt == PH_ACK) || (phase_nxt == PH_WAIT_DATA);
    out_data_nxt = {1'b0, err_nxt, ok_nxt, temp_nxt, hum_nxt, rising, drive_low,
                    status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      last_r      <= '0;
      frame_r     <= '0;
      count_r     <= '0;
      hum_r       <= '0;
      temp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        last_r  <= last_nxt;
        frame_r <= frame_nxt;
        count_r <= count_nxt;
        hum_r   <= hum_nxt;
        temp_r  <= temp_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_ok_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[37] |-> out_data_r[1:0] == ST_READY)
    else $error("frame_ok without ready status");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[38] |-> out_data_r[1:0] == ST_IDLE)
    else $error("frame_error without idle status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CountW'(FrameBits))
    else $error("bit count out of range");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> count_r == '0 && frame_r == '0)
    else $error("partial frame left in idle");

endmodule
`default_nettype wire

// File: tb/tb_single_wire_sensor_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_wire_sensor_frame_receiver
// Self-checking bench for the single-wire sensor frame receiver. Requests are
// events (start, pulse elapsed, line edge, consumed) fed as whole sensor frames
// with random content and pulse widths, broken frames, aborts and noise, over
// several tolerance and offset settings. A request-level predictor in the
// scoreboard works out every result, which is compared field by field.
// ----------------------------------------------------------------------------
import swsr_pkg::*;

typedef struct {
  status_t            status;
  logic               drive_low;
  logic               edge_rising;
  logic [15:0]        humidity;
  logic signed [16:0] temperature;
  logic               frame_ok;
  logic               frame_error;
} reading_t;

class sensor_frame_scoreboard;
  logic [TolW-1:0]           tol;
  logic signed [OffsetW-1:0] offset;
  phase_t                    phase;
  logic [15:0]               last_stamp;
  logic [FrameBits-1:0]      shift;
  int                        bits_in;
  logic [15:0]               humidity;
  logic signed [TempW-1:0]   temperature;
  reading_t                  expected_readings[$];
  int                        mismatches;
  int                        requests;
  int                        frames_ok;
  int                        frames_bad;

  function new();
    tol         = 8'd10;
    offset      = '0;
    phase       = PH_IDLE;
    last_stamp  = '0;
    shift       = '0;
    bits_in     = 0;
    humidity    = '0;
    temperature = '0;
    mismatches  = 0;
    requests    = 0;
    frames_ok   = 0;
    frames_bad  = 0;
  endfunction

  function void load_register(cfg_idx_t idx, logic [OffsetW-1:0] data);
    if (idx == CFG_TOLERANCE) begin
      tol = data[TolW-1:0];
    end else begin
      offset = data;
    end
  endfunction

  function bit fits(int width, int nominal);
    return width >= nominal - int'(tol) && width <= nominal + int'(tol);
  endfunction

  function void drop_frame();
    phase   = PH_IDLE;
    shift   = '0;
    bits_in = 0;
  endfunction

  function void note_request(op_t op, logic [15:0] stamp);
    logic [15:0] span;
    logic [15:0] hum_raw;
    logic [15:0] temp_raw;
    logic [7:0]  sum;
    int          width;
    int          celsius;
    bit          passed;
    bit          failed;
    reading_t    r;
    passed = 0;
    failed = 0;
    requests++;
    case (op)
      OP_START: begin
        if (phase == PH_IDLE || phase == PH_READY) phase = PH_START;
      end
      OP_ELAPSED: begin
        if (phase == PH_START) begin
          phase      = PH_WAIT_ACK;
          last_stamp = stamp;
        end
      end
      OP_CONSUMED: begin
        drop_frame();
      end
      default: begin
        if (phase >= PH_WAIT_ACK && phase <= PH_DATA) begin
          span       = stamp - last_stamp;
          width      = int'(span >> 1);
          last_stamp = stamp;
          case (phase)
            PH_WAIT_ACK: begin
              phase = PH_ACK;
            end
            PH_ACK, PH_WAIT_DATA_START: begin
              if (!fits(width, int'(NomAck))) begin
                failed = 1;
              end else if (phase == PH_ACK) begin
                phase = PH_WAIT_DATA_START;
              end else begin
                phase = PH_WAIT_DATA;
              end
            end
            PH_WAIT_DATA: begin
              if (fits(width, int'(NomLow))) phase = PH_DATA;
              else failed = 1;
            end
            default: begin
              if (fits(width, int'(NomZero)) || fits(width, int'(NomOne))) begin
                shift = {shift[FrameBits-2:0], !fits(width, int'(NomZero))};
                bits_in++;
                phase = PH_WAIT_DATA;
                if (bits_in == FrameBits) begin
                  hum_raw  = shift[39:24];
                  temp_raw = shift[23:8];
                  sum = hum_raw[7:0] + hum_raw[15:8] + temp_raw[7:0] + temp_raw[15:8];
                  if (sum != shift[7:0]) begin
                    failed = 1;
                  end else begin
                    celsius = int'(temp_raw[14:0]);
                    if (temp_raw[15]) celsius = -celsius;
                    celsius     = celsius + int'(offset);
                    temperature = celsius[TempW-1:0];
                    humidity    = hum_raw;
                    shift       = '0;
                    bits_in     = 0;
                    phase       = PH_READY;
                    passed      = 1;
                    frames_ok++;
                  end
                end
              end else begin
                failed = 1;
              end
            end
          endcase
          if (failed) begin
            drop_frame();
            frames_bad++;
          end
        end
      end
    endcase

    if (phase == PH_READY) begin
      r.status = ST_READY;
    end else if (phase == PH_IDLE) begin
      r.status = ST_IDLE;
    end else begin
      r.status = ST_BUSY;
    end
    r.drive_low   = (phase == PH_START);
    r.edge_rising = (phase == PH_ACK || phase == PH_WAIT_DATA);
    r.humidity    = humidity;
    r.temperature = temperature;
    r.frame_ok    = passed;
    r.frame_error = failed;
    expected_readings.push_back(r);
  endfunction

  function void compare_field(string field, logic signed [31:0] want,
                              logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(logic [39:0] word);
    reading_t want;
    if (expected_readings.size() == 0) begin
      mismatches++;
      $display("%0t ns: result expected none, got %h", $time, word);
      return;
    end
    want = expected_readings.pop_front();
    compare_field("status", want.status, word[1:0]);
    compare_field("drive_low", want.drive_low, word[2]);
    compare_field("edge_rising", want.edge_rising, word[3]);
    compare_field("humidity", want.humidity, word[19:4]);
    compare_field("temperature", want.temperature, $signed(word[36:20]));
    compare_field("frame_ok", want.frame_ok, word[37]);
    compare_field("frame_error", want.frame_error, word[38]);
  endfunction
endclass

module tb_single_wire_sensor_frame_receiver;

  localparam int CycleLimit      = 250000;
  localparam int ItemsPerSetting = 260;
  localparam int Settings        = 5;
  localparam int AckUs           = int'(NomAck);
  localparam int LowUs           = int'(NomLow);
  localparam int ZeroUs          = int'(NomZero);
  localparam int OneUs           = int'(NomOne);
  localparam int TolSet [Settings] = '{10, 0, 255, 37, 3};
  localparam int OffSet [Settings] = '{0, -500, 500, -1, 211};

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata   = '0;
  logic [1:0]         in_tuser   = OP_START;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [39:0]        out_tdata;
  logic               cfg_we     = 1'b0;
  cfg_idx_t           cfg_addr   = CFG_TOLERANCE;
  logic [OffsetW-1:0] cfg_wdata  = '0;

  sensor_frame_scoreboard readings;
  logic [15:0]            stamp_now = '0;
  int                     tol_now   = 10;
  int                     sent      = 0;
  int                     cycles    = 0;
  bit                     steady    = 0;

  single_wire_sensor_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) readings.note_request(op_t'(in_tuser), in_tdata);
    if (rst_n && out_tvalid && out_tready) readings.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("single_wire_sensor_frame_receiver verification failed");
      $finish;
    end
  end

  task automatic send_request(op_t op, logic [15:0] stamp);
    while (!steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_edge(int width_us);
    stamp_now = stamp_now + 16'(2 * width_us + $urandom_range(1));
    send_request(OP_EDGE, stamp_now);
  endtask

  function automatic int good_width(int nominal);
    return $urandom_range(nominal + tol_now, (nominal > tol_now) ? nominal - tol_now : 0);
  endfunction

  // keep a one bit clear of the zero window so it always decodes as one
  function automatic int one_width();
    int lo;
    lo = OneUs - tol_now;
    if (lo <= ZeroUs + tol_now) lo = ZeroUs + tol_now + 1;
    return $urandom_range(OneUs + tol_now, lo);
  endfunction

  function automatic int bad_width(int nominal, bit low_side_ok);
    if (low_side_ok && nominal > tol_now && $urandom_range(1))
      return $urandom_range(nominal - tol_now - 1, 0);
    return nominal + tol_now + 1 + $urandom_range(2000);
  endfunction

  // mode 0 clean, 1 bad checksum, 2 bad pulse width, 3 consumed mid-frame
  task automatic send_frame(int mode);
    logic [15:0] hum;
    logic [15:0] temp;
    logic [7:0]  check;
    logic [39:0] word;
    int          widths[$];
    int          cut;
    hum   = 16'($urandom);
    temp  = 16'($urandom);
    check = hum[7:0] + hum[15:8] + temp[7:0] + temp[15:8];
    if (mode == 1) check = check ^ 8'($urandom_range(255, 1));
    word = {hum, temp, check};
    widths.push_back($urandom_range(3000));
    widths.push_back(good_width(AckUs));
    widths.push_back(good_width(AckUs));
    for (int b = 39; b >= 0; b--) begin
      widths.push_back(good_width(LowUs));
      widths.push_back(word[b] ? one_width() : good_width(ZeroUs));
    end
    cut = $urandom_range(widths.size() - 2, 1);
    if (mode == 2) begin
      if (cut >= 4 && cut % 2 == 0) widths[cut] = bad_width(OneUs, 0);
      else widths[cut] = bad_width((cut <= 2) ? AckUs : LowUs, 1);
    end
    send_request(OP_START, 16'($urandom));
    stamp_now = 16'($urandom);
    send_request(OP_ELAPSED, stamp_now);
    foreach (widths[i]) begin
      if (mode == 3 && i == cut) begin
        send_request(OP_CONSUMED, 16'($urandom));
        return;
      end
      // start and pulse elapsed are ignored while a frame is in flight
      if ($urandom_range(99) < 2) send_request(op_t'($urandom_range(1)), 16'($urandom));
      send_edge(widths[i]);
      if (mode == 2 && i == cut) return;
    end
  endtask

  task automatic run_sequence();
    int pick;
    int mode;
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(5, 1)) send_request(op_t'($urandom_range(3)), 16'($urandom));
    end else begin
      mode = (pick < 70) ? 0 : $urandom_range(3, 1);
      send_frame(mode);
      if (mode == 0) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          send_request(OP_EDGE, 16'($urandom));
          send_request(OP_ELAPSED, 16'($urandom));
        end
        if (pick < 60) send_request(OP_CONSUMED, 16'($urandom));
      end
    end
  endtask

  task automatic run_directed();
    send_request(OP_ELAPSED, 16'hFFFF);   // pulse elapsed while idle
    send_request(OP_EDGE, 16'h0000);      // edge while idle
    send_request(OP_CONSUMED, 16'h8421);
    send_request(OP_START, 16'hFFFF);
    send_request(OP_START, 16'h0000);     // start while busy
    send_request(OP_EDGE, 16'hAAAA);      // edge during start pulse
    stamp_now = 16'hFFF0;
    send_request(OP_ELAPSED, stamp_now);
    send_request(OP_ELAPSED, 16'h5555);
    send_edge(12);                        // first edge, unchecked, wraps the timer
    send_edge(AckUs);
    send_edge(AckUs + 10);
    send_edge(LowUs - 10);
    send_edge(ZeroUs);
    send_edge(LowUs);
    send_edge(OneUs + 11);                // bit pulse too long
    send_request(OP_EDGE, 16'h7FFF);
    send_request(OP_START, 16'h0F0F);
    stamp_now = 16'hFFFE;
    send_request(OP_ELAPSED, stamp_now);
    send_edge(32767);                     // widest span the timer allows
    send_edge(AckUs - 11);                // handshake pulse too short
    send_request(OP_START, 16'hF0F0);
    send_request(OP_ELAPSED, 16'h0001);
    send_request(OP_CONSUMED, 16'hFFFF);  // consumed while busy
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (readings.expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(int tol, int off);
    logic [OffsetW-1:0] tol_word;
    tol_word = {2'($urandom), 8'(tol)};
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_TOLERANCE;
    cfg_wdata <= tol_word;
    @(posedge clk);
    cfg_addr  <= CFG_TEMP_OFFSET;
    cfg_wdata <= 10'(off);
    @(posedge clk);
    cfg_we <= 1'b0;
    readings.load_register(CFG_TOLERANCE, tol_word);
    readings.load_register(CFG_TEMP_OFFSET, 10'(off));
    tol_now = tol;
  endtask

  initial begin
    int target;
    readings = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int s = 0; s < Settings; s++) begin
      if (s > 0) begin
        wait_quiet();
        load_settings(TolSet[s], OffSet[s]);
      end
      steady = (s == 2);
      if (s == 0) run_directed();
      target = sent + ItemsPerSetting;
      while (sent < target) run_sequence();
    end
    wait_quiet();
    $display("%0d requests over %0d tolerance/offset settings in %0d cycles",
             readings.requests, Settings, cycles);
    $display("frames passed %0d, frames rejected %0d, mismatches %0d",
             readings.frames_ok, readings.frames_bad, readings.mismatches);
    if (readings.mismatches == 0) begin
      $display("single_wire_sensor_frame_receiver verification clean");
    end else begin
      $display("single_wire_sensor_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
